/* rtl/assert_macros.svh */
// Assertion macros for the translation buffer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, switched off while reset is held.
`define FTLB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("translation buffer assertion failed");

// Checked property that also holds across reset.
`define FTLB_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("translation buffer reset assertion failed");

`endif

/* rtl/ftlb_pkg.sv */
// Package with the shared types and constants of the translation buffer.
package ftlb_pkg;

  localparam int OUT_FRAME_W = 16;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  // Broadcast control from the sequencer to every entry cell.
  typedef struct packed {
    logic ins;    // insert transaction accepted this cycle
    logic shift;  // buffer is full, so an insert shifts every entry up
    logic cmp;    // lookup transaction accepted this cycle
  } ftlb_ctrl_t;

endpackage

/* rtl/ftlb_cell.sv */
// One entry cell of the buffer: stores a page/frame pair and compares on lookup.
module ftlb_cell import ftlb_pkg::*; #(
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ftlb_ctrl_t            ctrl,
  input  logic [PAGE_BITS-1:0]  new_page,
  input  logic [FRAME_BITS-1:0] new_frame,
  input  logic                  prev_valid,
  input  logic [PAGE_BITS-1:0]  prev_page,
  input  logic [FRAME_BITS-1:0] prev_frame,
  output logic                  valid_o,
  output logic [PAGE_BITS-1:0]  page_o,
  output logic [FRAME_BITS-1:0] frame_o,
  output logic                  match_o
);

  logic                  valid_r, valid_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic                  match_r, match_nxt;

  always_comb begin
    valid_nxt = valid_r;
    page_nxt  = page_r;
    frame_nxt = frame_r;
    match_nxt = match_r;
    if (ctrl.ins) begin
      if (ctrl.shift) begin
        valid_nxt = prev_valid;
        page_nxt  = prev_page;
        frame_nxt = prev_frame;
      end else if (!valid_r && prev_valid) begin
        // Valid entries form a prefix, so this is the lowest empty cell.
        valid_nxt = 1'b1;
        page_nxt  = new_page;
        frame_nxt = new_frame;
      end
    end
    if (ctrl.cmp) begin
      match_nxt = valid_r && (page_r == new_page);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
    page_r  <= page_nxt;
    frame_r <= frame_nxt;
  end

  assign valid_o = valid_r;
  assign page_o  = page_r;
  assign frame_o = frame_r;
  assign match_o = match_r;

endmodule

/* rtl/ftlb_pick.sv */
// Priority select: the highest-indexed matching cell supplies the frame.
module ftlb_pick import ftlb_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int FRAME_BITS = 16
) (
  input  logic [ENTRIES-1:0]    match_i,
  input  logic [FRAME_BITS-1:0] frame_i [ENTRIES],
  output logic                  hit_o,
  output logic [FRAME_BITS-1:0] frame_o
);

  logic [ENTRIES-1:0] win;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      win[i] = match_i[i] && ((match_i >> (i + 1)) == '0);
    end
  end

  always_comb begin
    frame_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      frame_o = frame_o | (frame_i[i] & {FRAME_BITS{win[i]}});
    end
  end

  assign hit_o = |match_i;

endmodule

/* rtl/fifo_tlb_lookup_insert_top.sv */
// Top level of the fully associative translation buffer with shift-up replacement.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_mode, in_page, in_frame
//   out_     output     out_valid/out_stall out_hit, out_found_frame
//
// On an insert the cell row updates and the result register loads in the same cycle.
// A lookup first has the cells register their compare, then the priority
// select loads the result register.
// Reset (rst_n low, synchronous) empties every entry and the result register.
// A new transaction is taken while the result register drains; the input stalls
// during the select cycle and while a held result is stalled.
`include "assert_macros.svh"

module fifo_tlb_lookup_insert_top import ftlb_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_mode,
  input  logic [PAGE_BITS-1:0]   in_page,
  input  logic [FRAME_BITS-1:0]  in_frame,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_hit,
  output logic [OUT_FRAME_W-1:0] out_found_frame
);

  typedef enum logic {ST_IDLE, ST_SEL} state_t;

  state_t                 state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r, out_hit_nxt;
  logic [OUT_FRAME_W-1:0] out_found_frame_r, out_found_frame_nxt;

  ftlb_ctrl_t             ctrl;
  logic                   in_acc;
  logic                   cell_valid [ENTRIES];
  logic [PAGE_BITS-1:0]   cell_page  [ENTRIES];
  logic [FRAME_BITS-1:0]  cell_frame [ENTRIES];
  logic [ENTRIES-1:0]     valid_vec;
  logic [ENTRIES-1:0]     match_vec;
  logic                   pick_hit;
  logic [FRAME_BITS-1:0]  pick_frame;

  assign in_stall = (state_r == ST_SEL) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign ctrl.ins   = in_acc && (in_mode == MODE_INSERT);
  assign ctrl.cmp   = in_acc && (in_mode == MODE_LOOKUP);
  assign ctrl.shift = valid_vec[ENTRIES-1];

  // Cell 0 takes the new pair from the input on a shift; the rest take their neighbor.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      ftlb_cell #(
        .PAGE_BITS (PAGE_BITS),
        .FRAME_BITS(FRAME_BITS)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .new_page  (in_page),
        .new_frame (in_frame),
        .prev_valid(1'b1),
        .prev_page (in_page),
        .prev_frame(in_frame),
        .valid_o   (cell_valid[g]),
        .page_o    (cell_page[g]),
        .frame_o   (cell_frame[g]),
        .match_o   (match_vec[g])
      );
    end else begin : g_body
      ftlb_cell #(
        .PAGE_BITS (PAGE_BITS),
        .FRAME_BITS(FRAME_BITS)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .new_page  (in_page),
        .new_frame (in_frame),
        .prev_valid(cell_valid[g-1]),
        .prev_page (cell_page[g-1]),
        .prev_frame(cell_frame[g-1]),
        .valid_o   (cell_valid[g]),
        .page_o    (cell_page[g]),
        .frame_o   (cell_frame[g]),
        .match_o   (match_vec[g])
      );
    end
    assign valid_vec[g] = cell_valid[g];
  end

  ftlb_pick #(
    .ENTRIES   (ENTRIES),
    .FRAME_BITS(FRAME_BITS)
  ) u_pick (
    .match_i(match_vec),
    .frame_i(cell_frame),
    .hit_o  (pick_hit),
    .frame_o(pick_frame)
  );

  always_comb begin
    state_nxt           = state_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_hit_nxt         = out_hit_r;
    out_found_frame_nxt = out_found_frame_r;
    case (state_r)
      ST_IDLE: begin
        if (ctrl.ins) begin
          out_valid_nxt       = 1'b1;
          out_hit_nxt         = 1'b0;
          out_found_frame_nxt = '0;
        end else if (ctrl.cmp) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        state_nxt           = ST_IDLE;
        out_valid_nxt       = 1'b1;
        out_hit_nxt         = pick_hit;
        out_found_frame_nxt = OUT_FRAME_W'(pick_frame);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_hit_r         <= out_hit_nxt;
    out_found_frame_r <= out_found_frame_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_found_frame = out_found_frame_r;

  `FTLB_ASSERT(a_valid_prefix, ((valid_vec + 1'b1) & valid_vec) == '0)
  `FTLB_ASSERT(a_sel_out_free, (state_r == ST_SEL) |-> !out_valid_r)
  `FTLB_ASSERT(a_insert_result, ctrl.ins |=> (out_valid_r && !out_hit_r))
  `FTLB_ASSERT(a_lookup_sel, ctrl.cmp |=> (state_r == ST_SEL))
  `FTLB_ASSERT_RST(a_reset_empty, !rst_n |=> (valid_vec == '0))

endmodule
